// ----- design/usv_pkg.sv -----
`default_nettype none
package usv_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_SEGMENTS_DEF = 254;
    localparam int MIN_SEGMENTS     = 3;

    localparam int RADIUS_W  = 24;
    localparam int SEG_W     = 8;
    localparam int COORD_W   = 8;
    localparam int POS_W     = 26;
    localparam int VNUM_W    = 16;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 8'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 24'd65536;
    localparam logic [SEG_W-1:0]    SEGMENTS_RESET = 8'd16;

    // Phases are fractions of a full turn in 32 bits.
    localparam int PHASE_BITS = 32;

    // pi scaled by 2^32.
    localparam logic [33:0] PI_Q32 = 34'd13493037705;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Series divisors replaced by reciprocals: floor(p / d) = (p * M) >> K for p < 2^30.
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;
    localparam logic [31:0] SIN_M [SIN_TERMS] = '{
        32'd1249445032, 32'd1908874354, 32'd1636178018, 32'd1717986919, 32'd1431655766
    };
    localparam int SIN_K [SIN_TERMS] = '{37, 37, 36, 35, 33};
    localparam logic [31:0] COS_M [COS_TERMS] = '{
        32'd2082408386, 32'd1527099484, 32'd1227133514,
        32'd1145324613, 32'd1431655766, 32'd1073741825
    };
    localparam int COS_K [COS_TERMS] = '{38, 37, 36, 35, 34, 31};

    // Pipeline latencies of the sub-blocks, in enabled cycles.
    localparam int DIV_LAT = PHASE_BITS + 2;
    localparam int SC_LAT  = 2 * COS_TERMS + 4;
    localparam int VO_LAT  = 4;

endpackage
`default_nettype wire

// ----- design/usv_delay.sv -----
`default_nettype none
module usv_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
`default_nettype wire

// ----- design/usv_phase_div.sv -----
`default_nettype none
module usv_phase_div #(
    parameter int FRAC_BITS = usv_pkg::FRAC_BITS_DEF,
    parameter bit HALF_TURN = 1'b0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [7:0]           num,
    input  logic [7:0]           den,
    output logic [31:0]          phase,
    output logic [FRAC_BITS:0]   frac
);

    // One quotient bit per stage: restoring long division of num by den.
    localparam int STEPS = usv_pkg::PHASE_BITS;
    localparam int PSTEP = HALF_TURN ? STEPS - 1 : STEPS;

    logic [STEPS:0] quo_reg  [STEPS+1];
    logic [7:0]     rem_reg  [STEPS+1];
    logic [7:0]     remp_reg [STEPS+1];
    logic [7:0]     remf_reg [STEPS+1];
    logic [31:0]    phase_reg;
    logic [FRAC_BITS:0] frac_reg;

    logic       ge0;
    logic [7:0] r0;

    assign ge0 = num >= den;
    assign r0  = ge0 ? 8'(num - den) : num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg[0]  <= {{STEPS{1'b0}}, ge0};
            rem_reg[0]  <= r0;
            remp_reg[0] <= r0;
            remf_reg[0] <= r0;
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [8:0] trial;
        logic [8:0] diff;
        logic       ge;
        logic [7:0] rnew;

        assign trial = {rem_reg[k-1], 1'b0};
        assign ge    = trial >= {1'b0, den};
        assign diff  = trial - {1'b0, den};
        assign rnew  = ge ? diff[7:0] : trial[7:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k]  <= {quo_reg[k-1][STEPS-1:0], ge};
                rem_reg[k]  <= rnew;
                remp_reg[k] <= (k == PSTEP) ? rnew : remp_reg[k-1];
                remf_reg[k] <= (k == FRAC_BITS) ? rnew : remf_reg[k-1];
            end
        end
    end

    // Round half up: one more when remainder plus half the divisor reaches it.
    logic [8:0]  half;
    logic        up_p;
    logic        up_f;
    logic [31:0] phase_trunc;

    assign half = {2'b0, den[7:1]};
    assign up_p = ({1'b0, remp_reg[STEPS]} + half) >= {1'b0, den};
    assign up_f = ({1'b0, remf_reg[STEPS]} + half) >= {1'b0, den};

    if (HALF_TURN)
    begin : g_half
        assign phase_trunc = quo_reg[STEPS][STEPS:1];
    end
    else
    begin : g_full
        assign phase_trunc = quo_reg[STEPS][STEPS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= phase_trunc + 32'(up_p);
            frac_reg  <= quo_reg[STEPS][STEPS -: FRAC_BITS+1] + (FRAC_BITS+1)'(up_f);
        end
    end

    assign phase = phase_reg;
    assign frac  = frac_reg;

endmodule
`default_nettype wire

// ----- design/usv_sincos.sv -----
`default_nettype none
module usv_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    localparam int NC = usv_pkg::COS_TERMS;
    localparam int NS = usv_pkg::SIN_TERMS;

    // Octant fold.
    logic [29:0] f;
    logic        sw;
    logic [29:0] g;
    logic [1:0]  q1_reg;
    logic        sw1_reg;
    logic [29:0] g1_reg;

    assign f  = phase[29:0];
    assign sw = f > 30'h2000_0000;
    assign g  = sw ? 30'(31'h4000_0000 - {1'b0, f}) : f;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg  <= phase[31:30];
            sw1_reg <= sw;
            g1_reg  <= g;
        end
    end

    // Phase to radians in Q30.
    logic [63:0] gp;
    logic [1:0]  q2_reg;
    logic        sw2_reg;
    logic [29:0] x2s_reg;

    assign gp = 64'(g1_reg) * 64'(usv_pkg::PI_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg  <= q1_reg;
            sw2_reg <= sw1_reg;
            x2s_reg <= 30'((gp + 64'h1_0000_0000) >> 33);
        end
    end

    // Square of the angle.
    logic [63:0] xx;
    logic [1:0]  q3_reg;
    logic        sw3_reg;
    logic [29:0] x3_reg;
    logic [29:0] xsq3_reg;

    assign xx = 64'(x2s_reg) * 64'(x2s_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3_reg   <= q2_reg;
            sw3_reg  <= sw2_reg;
            x3_reg   <= x2s_reg;
            xsq3_reg <= 30'((xx + 64'h2000_0000) >> 30);
        end
    end

    // Horner steps, each a multiply stage and a reciprocal-divide stage.
    logic [30:0] ts_in  [NC];
    logic [30:0] tc_in  [NC];
    logic [29:0] x_in   [NC];
    logic [29:0] xsq_in [NC];
    logic [1:0]  q_in   [NC];
    logic        sw_in  [NC];

    logic [30:0] ps_reg  [NC];
    logic [30:0] pc_reg  [NC];
    logic [29:0] mx_reg  [NC];
    logic [29:0] mxs_reg [NC];
    logic [1:0]  mq_reg  [NC];
    logic        msw_reg [NC];

    logic [30:0] ts_reg  [NC];
    logic [30:0] tc_reg  [NC];
    logic [29:0] dx_reg  [NC];
    logic [29:0] dxs_reg [NC];
    logic [1:0]  dq_reg  [NC];
    logic        dsw_reg [NC];

    for (genvar i = 0; i < NC; i++)
    begin : g_term
        logic [63:0] prod_s;
        logic [63:0] prod_c;
        logic [63:0] rec_c;
        logic [30:0] ts_next;

        if (i == 0)
        begin : g_first
            assign ts_in[i]  = usv_pkg::Q30_ONE;
            assign tc_in[i]  = usv_pkg::Q30_ONE;
            assign x_in[i]   = x3_reg;
            assign xsq_in[i] = xsq3_reg;
            assign q_in[i]   = q3_reg;
            assign sw_in[i]  = sw3_reg;
        end
        else
        begin : g_next
            assign ts_in[i]  = ts_reg[i-1];
            assign tc_in[i]  = tc_reg[i-1];
            assign x_in[i]   = dx_reg[i-1];
            assign xsq_in[i] = dxs_reg[i-1];
            assign q_in[i]   = dq_reg[i-1];
            assign sw_in[i]  = dsw_reg[i-1];
        end

        if (i < NS)
        begin : g_sin
            logic [63:0] rec_s;
            assign prod_s  = 64'(xsq_in[i]) * 64'(ts_in[i]);
            assign rec_s   = 64'(ps_reg[i]) * 64'(usv_pkg::SIN_M[i]);
            assign ts_next = usv_pkg::Q30_ONE - 31'(rec_s >> usv_pkg::SIN_K[i]);
        end
        else
        begin : g_sin_last
            // The last slot forms sin = x * t.
            assign prod_s  = 64'(x_in[i]) * 64'(ts_in[i]);
            assign ts_next = ps_reg[i];
        end

        assign prod_c = 64'(xsq_in[i]) * 64'(tc_in[i]);
        assign rec_c  = 64'(pc_reg[i]) * 64'(usv_pkg::COS_M[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg[i]  <= 31'(prod_s >> 30);
                pc_reg[i]  <= 31'(prod_c >> 30);
                mx_reg[i]  <= x_in[i];
                mxs_reg[i] <= xsq_in[i];
                mq_reg[i]  <= q_in[i];
                msw_reg[i] <= sw_in[i];

                ts_reg[i]  <= ts_next;
                tc_reg[i]  <= usv_pkg::Q30_ONE - 31'(rec_c >> usv_pkg::COS_K[i]);
                dx_reg[i]  <= mx_reg[i];
                dxs_reg[i] <= mxs_reg[i];
                dq_reg[i]  <= mq_reg[i];
                dsw_reg[i] <= msw_reg[i];
            end
        end
    end

    // Undo the octant and quadrant folds.
    logic signed [31:0] s_oct;
    logic signed [31:0] c_oct;
    logic signed [31:0] s_next;
    logic signed [31:0] c_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    assign s_oct = $signed({1'b0, (dsw_reg[NC-1] ? tc_reg[NC-1] : ts_reg[NC-1])});
    assign c_oct = $signed({1'b0, (dsw_reg[NC-1] ? ts_reg[NC-1] : tc_reg[NC-1])});

    always_comb
    begin
        case (dq_reg[NC-1])
            2'd0:
            begin
                s_next = s_oct;
                c_next = c_oct;
            end
            2'd1:
            begin
                s_next = c_oct;
                c_next = -s_oct;
            end
            2'd2:
            begin
                s_next = -s_oct;
                c_next = -c_oct;
            end
            default:
            begin
                s_next = -c_oct;
                c_next = s_oct;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= s_next;
            cos_reg <= c_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule
`default_nettype wire

// ----- design/usv_vertex_out.sv -----
`default_nettype none
module usv_vertex_out #(
    parameter int FRAC_BITS = usv_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [usv_pkg::RADIUS_W-1:0]       radius,
    input  logic signed [31:0]                 sin_t,
    input  logic signed [31:0]                 cos_t,
    input  logic signed [31:0]                 sin_p,
    input  logic signed [31:0]                 cos_p,
    output logic signed [usv_pkg::POS_W-1:0]   px,
    output logic signed [usv_pkg::POS_W-1:0]   py,
    output logic signed [usv_pkg::POS_W-1:0]   pz,
    output logic signed [FRAC_BITS+1:0]        nx,
    output logic signed [FRAC_BITS+1:0]        ny,
    output logic signed [FRAC_BITS+1:0]        nz
);

    localparam int NW = FRAC_BITS + 2;

    // Shift right with rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                        input int sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        res = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

    logic signed [63:0] mx_reg;
    logic signed [63:0] mz_reg;
    logic signed [31:0] cy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= 64'(sin_t) * 64'(cos_p);
            mz_reg <= 64'(sin_t) * 64'(sin_p);
            cy_reg <= cos_t;
        end
    end

    logic signed [31:0] ux_reg;
    logic signed [31:0] uy_reg;
    logic signed [31:0] uz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= 32'(round_shift(mx_reg, 30));
            uy_reg <= cy_reg;
            uz_reg <= 32'(round_shift(mz_reg, 30));
        end
    end

    logic signed [63:0] rad_s;
    logic signed [63:0] qx_reg;
    logic signed [63:0] qy_reg;
    logic signed [63:0] qz_reg;
    logic signed [NW-1:0] nx_reg;
    logic signed [NW-1:0] ny_reg;
    logic signed [NW-1:0] nz_reg;

    assign rad_s = $signed(64'(radius));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= rad_s * 64'(ux_reg);
            qy_reg <= rad_s * 64'(uy_reg);
            qz_reg <= rad_s * 64'(uz_reg);
            nx_reg <= NW'(round_shift(64'(ux_reg), 30 - FRAC_BITS));
            ny_reg <= NW'(round_shift(64'(uy_reg), 30 - FRAC_BITS));
            nz_reg <= NW'(round_shift(64'(uz_reg), 30 - FRAC_BITS));
        end
    end

    logic signed [usv_pkg::POS_W-1:0] px_reg;
    logic signed [usv_pkg::POS_W-1:0] py_reg;
    logic signed [usv_pkg::POS_W-1:0] pz_reg;
    logic signed [NW-1:0] nx2_reg;
    logic signed [NW-1:0] ny2_reg;
    logic signed [NW-1:0] nz2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= usv_pkg::POS_W'(round_shift(qx_reg, 30));
            py_reg  <= usv_pkg::POS_W'(round_shift(qy_reg, 30));
            pz_reg  <= usv_pkg::POS_W'(round_shift(qz_reg, 30));
            nx2_reg <= nx_reg;
            ny2_reg <= ny_reg;
            nz2_reg <= nz_reg;
        end
    end

    assign px = px_reg;
    assign py = py_reg;
    assign pz = pz_reg;
    assign nx = nx2_reg;
    assign ny = ny2_reg;
    assign nz = nz2_reg;

endmodule
`default_nettype wire

// ----- design/uv_sphere_vertex_generator.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    lat_row, lon_col
// out       source     out_valid / out_ready  pos_*, norm_*, tex_u, tex_v, vertex_number,
//                                             range_error
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One grid point enters per cycle while the output buffer is not full. Each point passes
// through the bit-serial division pipelines (one quotient bit per stage, 34 stages),
// then 16 sine/cosine stages and 4 multiply-and-round stages.
// Reset clears the valid bits, empties the output buffer and loads the config defaults.
// The whole pipeline holds when the two-entry output buffer is full; finished items
// wait there, and the pipeline keeps taking new points until the buffer fills.
module uv_sphere_vertex_generator #(
    parameter int FRAC_BITS    = usv_pkg::FRAC_BITS_DEF,
    parameter int MAX_SEGMENTS = usv_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [usv_pkg::COORD_W-1:0]         lat_row,
    input  logic [usv_pkg::COORD_W-1:0]         lon_col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [usv_pkg::POS_W-1:0]    pos_x,
    output logic signed [usv_pkg::POS_W-1:0]    pos_y,
    output logic signed [usv_pkg::POS_W-1:0]    pos_z,
    output logic signed [FRAC_BITS+1:0]         norm_x,
    output logic signed [FRAC_BITS+1:0]         norm_y,
    output logic signed [FRAC_BITS+1:0]         norm_z,
    output logic [FRAC_BITS:0]                  tex_u,
    output logic [FRAC_BITS:0]                  tex_v,
    output logic [usv_pkg::VNUM_W-1:0]          vertex_number,
    output logic                                range_error,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [usv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [usv_pkg::RADIUS_W-1:0]        cfg_data
);

    localparam int NW    = FRAC_BITS + 2;
    localparam int TW    = FRAC_BITS + 1;
    localparam int TOTAL = usv_pkg::DIV_LAT + usv_pkg::SC_LAT + usv_pkg::VO_LAT;

    typedef struct packed {
        logic signed [usv_pkg::POS_W-1:0] px;
        logic signed [usv_pkg::POS_W-1:0] py;
        logic signed [usv_pkg::POS_W-1:0] pz;
        logic signed [NW-1:0]             nx;
        logic signed [NW-1:0]             ny;
        logic signed [NW-1:0]             nz;
        logic [TW-1:0]                    tu;
        logic [TW-1:0]                    tv;
        logic [usv_pkg::VNUM_W-1:0]       vnum;
        logic                             err;
    } vertex_t;

    // Configuration registers. The user must write them only while the pipeline is empty
    // (the block does not enforce this), so every stage reads them directly.
    logic [usv_pkg::RADIUS_W-1:0] radius_reg;
    logic [usv_pkg::SEG_W-1:0]    segments_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= usv_pkg::RADIUS_RESET;
            segments_reg <= usv_pkg::SEGMENTS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                usv_pkg::CFG_RADIUS:   radius_reg   <= cfg_data;
                usv_pkg::CFG_SEGMENTS: segments_reg <= cfg_data[usv_pkg::SEG_W-1:0];
                default:               ;
            endcase
        end
    end

    // Segment count clamped into the supported range.
    logic [usv_pkg::SEG_W-1:0] seg;

    always_comb
    begin
        if (segments_reg < usv_pkg::SEG_W'(usv_pkg::MIN_SEGMENTS))
        begin
            seg = usv_pkg::SEG_W'(usv_pkg::MIN_SEGMENTS);
        end
        else if (segments_reg > usv_pkg::SEG_W'(MAX_SEGMENTS))
        begin
            seg = usv_pkg::SEG_W'(MAX_SEGMENTS);
        end
        else
        begin
            seg = segments_reg;
        end
    end

    // Global advance: every stage moves unless the output buffer is full.
    logic [1:0] count_reg;
    logic       en;

    assign en       = count_reg != 2'd2;
    assign in_ready = en;

    logic [TOTAL:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-1:0], in_valid};
        end
    end

    logic [usv_pkg::COORD_W-1:0] lat_reg;
    logic [usv_pkg::COORD_W-1:0] lon_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_reg <= lat_row;
            lon_reg <= lon_col;
        end
    end

    // Range check and linear index, carried alongside the arithmetic.
    logic                         err0;
    logic [usv_pkg::VNUM_W-1:0]   vnum0;
    logic                         err_d;
    logic [usv_pkg::VNUM_W-1:0]   vnum_d;

    assign err0  = (lat_reg > seg) || (lon_reg > seg);
    assign vnum0 = usv_pkg::VNUM_W'(lat_reg * ({1'b0, seg} + 9'd1)) +
                   usv_pkg::VNUM_W'(lon_reg);

    usv_delay #(
        .WIDTH (usv_pkg::VNUM_W + 1),
        .DEPTH (TOTAL)
    ) u_side_delay (
        .clk  (clk),
        .en   (en),
        .din  ({err0, vnum0}),
        .dout ({err_d, vnum_d})
    );

    // Angles and texture coordinates by long division.
    logic [31:0]   theta_ph;
    logic [31:0]   phi_ph;
    logic [TW-1:0] tv_div;
    logic [TW-1:0] tu_div;
    logic [TW-1:0] tv_d;
    logic [TW-1:0] tu_d;

    usv_phase_div #(
        .FRAC_BITS (FRAC_BITS),
        .HALF_TURN (1'b1)
    ) u_div_lat (
        .clk   (clk),
        .en    (en),
        .num   (lat_reg),
        .den   (seg),
        .phase (theta_ph),
        .frac  (tv_div)
    );

    usv_phase_div #(
        .FRAC_BITS (FRAC_BITS),
        .HALF_TURN (1'b0)
    ) u_div_lon (
        .clk   (clk),
        .en    (en),
        .num   (lon_reg),
        .den   (seg),
        .phase (phi_ph),
        .frac  (tu_div)
    );

    usv_delay #(
        .WIDTH (2 * TW),
        .DEPTH (usv_pkg::SC_LAT + usv_pkg::VO_LAT)
    ) u_tex_delay (
        .clk  (clk),
        .en   (en),
        .din  ({tu_div, tv_div}),
        .dout ({tu_d, tv_d})
    );

    logic signed [31:0] sin_t;
    logic signed [31:0] cos_t;
    logic signed [31:0] sin_p;
    logic signed [31:0] cos_p;

    usv_sincos u_sc_theta (
        .clk     (clk),
        .en      (en),
        .phase   (theta_ph),
        .sin_q30 (sin_t),
        .cos_q30 (cos_t)
    );

    usv_sincos u_sc_phi (
        .clk     (clk),
        .en      (en),
        .phase   (phi_ph),
        .sin_q30 (sin_p),
        .cos_q30 (cos_p)
    );

    logic signed [usv_pkg::POS_W-1:0] px_w;
    logic signed [usv_pkg::POS_W-1:0] py_w;
    logic signed [usv_pkg::POS_W-1:0] pz_w;
    logic signed [NW-1:0]             nx_w;
    logic signed [NW-1:0]             ny_w;
    logic signed [NW-1:0]             nz_w;

    usv_vertex_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vertex_out (
        .clk    (clk),
        .en     (en),
        .radius (radius_reg),
        .sin_t  (sin_t),
        .cos_t  (cos_t),
        .sin_p  (sin_p),
        .cos_p  (cos_p),
        .px     (px_w),
        .py     (py_w),
        .pz     (pz_w),
        .nx     (nx_w),
        .ny     (ny_w),
        .nz     (nz_w)
    );

    // Points off the grid report only the error flag.
    vertex_t vtx;

    always_comb
    begin
        vtx = '0;
        vtx.err = err_d;
        if (!err_d)
        begin
            vtx.px   = px_w;
            vtx.py   = py_w;
            vtx.pz   = pz_w;
            vtx.nx   = nx_w;
            vtx.ny   = ny_w;
            vtx.nz   = nz_w;
            vtx.tu   = tu_d;
            vtx.tv   = tv_d;
            vtx.vnum = vnum_d;
        end
    end

    // Two-entry output buffer decouples the pipeline from the consumer.
    vertex_t buf_reg [2];
    logic    wr_ptr_reg;
    logic    rd_ptr_reg;
    logic    push;
    logic    pop;
    vertex_t head;

    assign push = en && vld_reg[TOTAL];
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_reg + 2'(push) - 2'(pop);
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= vtx;
        end
    end

    assign head          = buf_reg[rd_ptr_reg];
    assign out_valid     = count_reg != 2'd0;
    assign pos_x         = head.px;
    assign pos_y         = head.py;
    assign pos_z         = head.pz;
    assign norm_x        = head.nx;
    assign norm_y        = head.ny;
    assign norm_z        = head.nz;
    assign tex_u         = head.tu;
    assign tex_v         = head.tv;
    assign vertex_number = head.vnum;
    assign range_error   = head.err;

    // The buffer never holds more than its two entries.
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output buffer overflow");

    // An error vertex carries zero payload.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> pos_x == 0 && norm_y == 0 && tex_u == 0 &&
        vertex_number == 0)
        else $error("error vertex with nonzero fields");

    // Nothing appears at the output without an item leaving the pipeline.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 && !vld_reg[TOTAL] |=> !out_valid)
        else $error("output valid without a finished item");

endmodule
`default_nettype wire

// ----- sim/tb_uv_sphere_vertex_generator.sv -----
`default_nettype none
module tb_uv_sphere_vertex_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import usv_pkg::*;

    localparam int FRAC = 16;
    localparam int MAXSEG = 254;
    localparam int DRAIN_CYCLES = 70;       // a little over the pipeline depth
    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned PI_TURN = 64'd13493037705;

    // One vertex as it leaves the block, fields at the port widths.
    typedef struct packed {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic signed [FRAC+1:0]   nx;
        logic signed [FRAC+1:0]   ny;
        logic signed [FRAC+1:0]   nz;
        logic [FRAC:0]            u;
        logic [FRAC:0]            v;
        logic [VNUM_W-1:0]        vnum;
        logic                     err;
    } vertex_t;

    typedef struct packed {
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] lon;
    } grid_point_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic [COORD_W-1:0] lat_row, lon_col;
    logic out_valid, out_ready;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [FRAC+1:0] norm_x, norm_y, norm_z;
    logic [FRAC:0] tex_u, tex_v;
    logic [VNUM_W-1:0] vertex_number;
    logic range_error;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RADIUS_W-1:0] cfg_data;

    uv_sphere_vertex_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .lat_row(lat_row), .lon_col(lon_col),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_u(tex_u), .tex_v(tex_v), .vertex_number(vertex_number),
        .range_error(range_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 20 ns clock period.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Shadow copies of the two configuration registers, updated on each cfg transfer.
    logic [RADIUS_W-1:0] radius_q;
    logic [SEG_W-1:0]    segments_q;

    grid_point_t pending_points[$];
    vertex_t     expected_vertices[$];
    int          mismatches;
    int          cycles;
    logic        in_taken;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_count;

    // Rounds a signed value by sh bits, halves away from zero.
    function automatic longint round_off(longint val, int sh);
        longint unsigned mag;
        mag = (val < 0) ? longint'(-val) : val;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (val < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Sine and cosine in Q30 of an angle given as a 32-bit fraction of a full turn.
    // The angle is folded into the first octant, where truncated Horner series apply.
    task automatic turn_sin_cos(input logic [31:0] phase, output longint s_out,
                                output longint c_out);
        longint unsigned sdiv[5];
        longint unsigned cdiv[6];
        longint unsigned frac, g, x, x2, acc, s0, c0;
        longint s, c;
        logic folded;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        frac = phase[29:0];
        folded = frac > (64'd1 << 29);
        g = folded ? (ONE_Q30 - frac) : frac;
        x = (g * PI_TURN + (64'd1 << 32)) >> 33;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        acc = ONE_Q30;
        for (int i = 0; i < 5; i++)
            acc = ONE_Q30 - ((x2 * acc) >> 30) / sdiv[i];
        s0 = (x * acc) >> 30;
        acc = ONE_Q30;
        for (int i = 0; i < 6; i++)
            acc = ONE_Q30 - ((x2 * acc) >> 30) / cdiv[i];
        c0 = acc;
        s = folded ? longint'(c0) : longint'(s0);
        c = folded ? longint'(s0) : longint'(c0);
        case (phase[31:30])
            2'd0: begin s_out = s;  c_out = c;  end
            2'd1: begin s_out = c;  c_out = -s; end
            2'd2: begin s_out = -s; c_out = -c; end
            default: begin s_out = -c; c_out = s; end
        endcase
    endtask

    // Predicts the vertex of one grid point under the current configuration.
    task automatic predict_vertex(input grid_point_t pt, output vertex_t vx);
        longint unsigned seg, lat, lon;
        logic [31:0] theta, phi;
        longint st, ct, sp, cp, nx, ny, nz, rad;
        vx = '0;
        lat = pt.lat;
        lon = pt.lon;
        seg = segments_q;
        if (seg < MIN_SEGMENTS)
            seg = MIN_SEGMENTS;
        if (seg > MAXSEG)
            seg = MAXSEG;
        if (lat > seg || lon > seg)
        begin
            vx.err = 1'b1;
        end
        else
        begin
            theta = ((lat << 31) + seg / 2) / seg;
            phi = ((lon << 32) + seg / 2) / seg;
            turn_sin_cos(theta, st, ct);
            turn_sin_cos(phi, sp, cp);
            nx = round_off(st * cp, 30);
            ny = ct;
            nz = round_off(st * sp, 30);
            rad = radius_q;
            vx.px = round_off(rad * nx, 30);
            vx.py = round_off(rad * ny, 30);
            vx.pz = round_off(rad * nz, 30);
            vx.nx = round_off(nx, 30 - FRAC);
            vx.ny = round_off(ny, 30 - FRAC);
            vx.nz = round_off(nz, 30 - FRAC);
            vx.u = ((lon << FRAC) + seg / 2) / seg;
            vx.v = ((lat << FRAC) + seg / 2) / seg;
            vx.vnum = lat * (seg + 1) + lon;
        end
    endtask

    // Input driver: works in bursts of random length separated by random gaps.
    // An item stays on the port until the rising edge that transfers it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    grid_point_t pt;
                    pt = pending_points.pop_front();
                    lat_row <= pt.lat;
                    lon_col <= pt.lon;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        // Some bursts run with no gap at all afterwards.
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: the stall pattern is drawn at random, and redrawn periodically, among always
    // ready, coin-flip ready and ready with a chance of one in four.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_count++;
            if (stall_count % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer
    // against the oldest prediction still waiting.
    always @(posedge clk)
    begin
        vertex_t got, want, pred;
        grid_point_t pt;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                        vertex_number, range_error};
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected vertex transfer: %p", got);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Vertex mismatch:\n  expected %p\n  actual   %p",
                                     want, got);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pt.lat = lat_row;
                pt.lon = lon_col;
                predict_vertex(pt, pred);
                expected_vertices.push_back(pred);
            end
        end
    end

    // Waits until every queued point is transferred and every vertex has come back,
    // then lets the pipeline settle so the block is idle.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || in_valid || expected_vertices.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [RADIUS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_RADIUS)
            radius_q = data;
        else if (idx == CFG_SEGMENTS)
            segments_q = data[SEG_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_point(input int lat, input int lon);
        grid_point_t pt;
        pt.lat = lat;
        pt.lon = lon;
        pending_points.push_back(pt);
    endtask

    // Mostly points on the grid of the effective segment count, the rest anywhere.
    task automatic add_random_points(input int count);
        int seg;
        seg = (segments_q < MIN_SEGMENTS) ? MIN_SEGMENTS :
              (segments_q > MAXSEG) ? MAXSEG : segments_q;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 6) == 0)
                add_point($urandom_range(0, 255), $urandom_range(0, 255));
            else
                add_point($urandom_range(0, seg), $urandom_range(0, seg));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        lat_row = '0;
        lon_col = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_taken = 1'b0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stall_count = 0;
        radius_q = RADIUS_RESET;
        segments_q = SEGMENTS_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points under the reset configuration: poles, equator, the seam
        // column, the grid corners and points just off the grid.
        add_point(0, 0);
        add_point(16, 0);
        add_point(8, 0);
        add_point(8, 4);
        add_point(8, 8);
        add_point(8, 12);
        add_point(8, 16);
        add_point(3, 16);
        add_point(16, 16);
        add_point(5, 7);
        add_point(17, 0);
        add_point(0, 17);
        add_point(255, 255);
        add_point(170, 85);
        add_point(85, 170);
        add_point(1, 15);
        wait_drained();

        // Segment count below three acts as three; zero radius.
        write_register(CFG_SEGMENTS, 0);
        write_register(CFG_RADIUS, 0);
        for (int la = 0; la <= 4; la++)
            add_point(la, la);
        add_random_points(120);
        wait_drained();

        write_register(CFG_SEGMENTS, 2);
        write_register(CFG_RADIUS, 24'hFFFFFF);
        add_point(3, 3);
        add_point(1, 2);
        add_random_points(150);
        wait_drained();

        // Largest grid and largest radius.
        write_register(CFG_SEGMENTS, 254);
        add_point(254, 254);
        add_point(127, 127);
        add_point(255, 0);
        add_point(0, 255);
        add_random_points(300);
        wait_drained();

        // Segment register above the maximum acts as the maximum.
        write_register(CFG_SEGMENTS, 255);
        write_register(CFG_RADIUS, 1);
        add_point(254, 254);
        add_random_points(150);
        wait_drained();

        write_register(CFG_SEGMENTS, 3);
        write_register(CFG_RADIUS, RADIUS_RESET);
        add_random_points(150);
        wait_drained();

        // Random settings, biased toward small grids.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_register(CFG_RADIUS, $urandom_range(0, 24'hFFFFFF));
            write_register(CFG_SEGMENTS, ($urandom_range(0, 1) == 0) ?
                           $urandom_range(3, 40) : $urandom_range(0, 255));
            add_random_points(135);
            wait_drained();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
